@@ sv/rmad_pkg.sv @@
// Package with the word types, constants and sequencer states of the running median core.
package rmad_pkg;

  localparam int unsigned DataW = 24;
  localparam int unsigned SeqW  = 32;

  localparam logic [DataW:0]  AIRVENT_NEAR = (DataW + 1)'(10);
  localparam logic [SeqW-1:0] SEQ_STEP     = SeqW'(1);

  typedef struct packed {
    logic [DataW-1:0] delta_release;
    logic [DataW-1:0] asserted_time;
    logic [SeqW-1:0]  tick_count;
  } in_word_t;

  typedef struct packed {
    logic             median_valid;
    logic [DataW-1:0] median_release;
    logic             top_is_airvent;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_FLAG,
    ST_FETCH,
    ST_PIVOT,
    ST_SCAN,
    ST_DONE
  } seq_state_t;

endpackage

@@ sv/running_median_airvent_detect_core.sv @@
// Top level of the running median filter with air-valve detection.
//
// The block takes one word on the in_ channel per wheel-sensor tick and
// returns exactly one word on the out_ channel for it. Both channels use
// valid and ready. The release intervals of the last RING_DEPTH ticks are
// kept in a small RAM; a break in the tick count empties the ring.
// Until the ring is full, the result carries median_valid low and zeros.
// Once full, the median is found by a less-than and a less-or-equal
// comparator that, for each stored entry in turn, count the entries below
// and up to it, reading the RAM one entry per cycle. At most RING_DEPTH
// entries are tried, each by a fetch, a pivot load and a scan of the ring;
// with a full ring a word passes the difference and flag steps, then this
// search, and in_ready rises again once its result enters the output
// register. Before the ring is full a word skips these steps and goes
// straight to the output step; in_ready is low while an item is at work.
// The result waits in an output register, so a stalled receiver holds
// only that word; the next item is accepted meanwhile and its result
// waits for the register to empty. Synchronous active-low reset empties
// the ring and the output register; there is no clearing pass.
module running_median_airvent_detect_core
  import rmad_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] RANK = CW'(RING_DEPTH / 2);

  seq_state_t state_r, state_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic          full_r, full_nxt;
  logic [AW-1:0] idx_i_r, idx_i_nxt;
  logic [AW-1:0] idx_j_r, idx_j_nxt;
  logic [CW-1:0] below_r, below_nxt;
  logic [CW-1:0] upto_r, upto_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_data_r, out_data_nxt;

  logic [SeqW-1:0]  last_seq_r, last_seq_nxt;
  logic [DataW-1:0] rel1_r, rel2_r, rel3_r, rel1_nxt, rel2_nxt, rel3_nxt;
  logic [DataW-1:0] asr1_r, asr2_r, asr1_nxt, asr2_nxt;
  logic [DataW:0]   diff_r, diff_nxt;
  logic             flag_r, flag_nxt;
  logic [DataW-1:0] pivot_r, pivot_nxt;

  logic             accept;
  logic             seq_break;
  logic [AW-1:0]    slot_eff;
  logic             full_eff;
  logic [AW-1:0]    ram_raddr;
  logic [DataW-1:0] ram_rdata;
  logic [DataW:0]   sum_w;
  logic             lt_w, le_w;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  assign seq_break = (full_r || (slot_r != '0)) &&
                     ((last_seq_r + SEQ_STEP) != in_data.tick_count);
  assign slot_eff  = seq_break ? '0 : slot_r;
  assign full_eff  = seq_break ? 1'b0 : full_r;

  assign sum_w = {1'b0, rel1_r} + {1'b0, rel2_r};
  assign lt_w  = ram_rdata <  pivot_r;
  assign le_w  = ram_rdata <= pivot_r;

  rmad_ram #(
    .WIDTH(DataW),
    .DEPTH(RING_DEPTH)
  ) u_release_ram (
    .clk  (clk),
    .we   (accept),
    .waddr(slot_eff),
    .wdata(in_data.delta_release),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    full_nxt      = full_r;
    idx_i_nxt     = idx_i_r;
    idx_j_nxt     = idx_j_r;
    below_nxt     = below_r;
    upto_nxt      = upto_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    last_seq_nxt  = last_seq_r;
    rel1_nxt      = rel1_r;
    rel2_nxt      = rel2_r;
    rel3_nxt      = rel3_r;
    asr1_nxt      = asr1_r;
    asr2_nxt      = asr2_r;
    diff_nxt      = diff_r;
    flag_nxt      = flag_r;
    pivot_nxt     = pivot_r;
    ram_raddr     = idx_i_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          slot_nxt     = (slot_eff == LAST) ? '0 : slot_eff + AW'(1);
          full_nxt     = full_eff || (slot_eff == LAST);
          last_seq_nxt = in_data.tick_count;
          rel1_nxt     = in_data.delta_release;
          rel2_nxt     = rel1_r;
          rel3_nxt     = rel2_r;
          asr1_nxt     = in_data.asserted_time;
          asr2_nxt     = asr1_r;
          state_nxt    = (full_eff || (slot_eff == LAST)) ? ST_DIFF : ST_DONE;
        end
      end
      ST_DIFF: begin
        diff_nxt  = (sum_w >= {1'b0, rel3_r}) ? sum_w - {1'b0, rel3_r}
                                              : {1'b0, rel3_r} - sum_w;
        idx_i_nxt = '0;
        state_nxt = ST_FLAG;
      end
      ST_FLAG: begin
        flag_nxt  = (diff_r < AIRVENT_NEAR) ||
                    (({2'b00, rel3_r} >= {diff_r, 1'b0}) &&
                     ({1'b0, asr2_r} > {asr1_r, 1'b0}));
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        ram_raddr = idx_i_r;
        state_nxt = ST_PIVOT;
      end
      ST_PIVOT: begin
        pivot_nxt = ram_rdata;
        ram_raddr = '0;
        idx_j_nxt = '0;
        below_nxt = '0;
        upto_nxt  = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        ram_raddr = (idx_j_r == LAST) ? '0 : idx_j_r + AW'(1);
        below_nxt = below_r + CW'(lt_w);
        upto_nxt  = upto_r + CW'(le_w);
        idx_j_nxt = idx_j_r + AW'(1);
        if (idx_j_r == LAST) begin
          if ((below_nxt <= RANK) && (RANK < upto_nxt)) begin
            state_nxt = ST_DONE;
          end else begin
            idx_i_nxt = (idx_i_r == LAST) ? '0 : idx_i_r + AW'(1);
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.median_valid   = full_r;
          out_data_nxt.median_release = full_r ? pivot_r : '0;
          out_data_nxt.top_is_airvent = full_r && flag_r;
          state_nxt                   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      full_r      <= 1'b0;
      idx_i_r     <= '0;
      idx_j_r     <= '0;
      below_r     <= '0;
      upto_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      full_r      <= full_nxt;
      idx_i_r     <= idx_i_nxt;
      idx_j_r     <= idx_j_nxt;
      below_r     <= below_nxt;
      upto_r      <= upto_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    last_seq_r <= last_seq_nxt;
    rel1_r     <= rel1_nxt;
    rel2_r     <= rel2_nxt;
    rel3_r     <= rel3_nxt;
    asr1_r     <= asr1_nxt;
    asr2_r     <= asr2_nxt;
    diff_r     <= diff_nxt;
    flag_r     <= flag_nxt;
    pivot_r    <= pivot_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= LAST)
    else $error("write slot beyond the ring");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("sequencer idle straight after an accepted word");

  a_counts_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (below_r <= upto_r))
    else $error("below count exceeds up-to count");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.median_valid) |->
      ((out_data_r.median_release == '0) && !out_data_r.top_is_airvent))
    else $error("result fields set while the ring is not full");

  a_median_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> full_r)
    else $error("median search started on a ring that is not full");
`endif

endmodule

@@ sv/rmad_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module rmad_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
